// ===== src/fvi_pkg.sv =====
// fvi_pkg: shared constants and register index codes for the fountain velocity block
// no dependencies; used by the top level, fvi_front, fvi_scale and fvi_div
`timescale 1ns / 1ps
`default_nettype none

package fvi_pkg;

  localparam int FIELD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int NUM_AXES = 3;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 4'd0,
    CFG_CENTER_Y    = 4'd1,
    CFG_CENTER_Z    = 4'd2,
    CFG_NORMAL_X    = 4'd3,
    CFG_NORMAL_Y    = 4'd4,
    CFG_NORMAL_Z    = 4'd5,
    CFG_RECT_WIDTH  = 4'd6,
    CFG_RECT_HEIGHT = 4'd7
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== src/fountain_velocity_init.sv =====
// fountain_velocity_init: top level, configuration registers, pipeline hookup and output register
// depends on fvi_pkg, fvi_front, fvi_sqrt, fvi_scale and fvi_div
`timescale 1ns / 1ps
`default_nettype none

// One position enters per clock and one velocity leaves per clock while the pipeline is
// not held. On its way to the output register an item passes the three front stages,
// one stage per root bit of the square root (W+2, where W is WORD_WIDTH capped at 32),
// two multiply stages, one stage per quotient bit plus a range check (W+2) and the output
// register. The whole pipeline holds while a result waits under out_stall with the output
// register full; bubbles inside it are not squeezed out.
// Velocity is (P + normal - center) / |P + normal - center| scaled by D2/d2, truncated
// toward zero and saturated to W bits; a zero distance or zero direction gives a zero
// velocity with out_div_fault set. Configuration is to be written by the user only while
// the block is idle; the block itself does not enforce this.

module fountain_velocity_init #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fvi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvi_pkg::FIELD_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fvi_pkg::FIELD_W-1:0]      in_pos_x,
  input  logic [fvi_pkg::FIELD_W-1:0]      in_pos_y,
  input  logic [fvi_pkg::FIELD_W-1:0]      in_pos_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fvi_pkg::FIELD_W-1:0]      out_vel_x,
  output logic [fvi_pkg::FIELD_W-1:0]      out_vel_y,
  output logic [fvi_pkg::FIELD_W-1:0]      out_vel_z,
  output logic                             out_div_fault
);

  localparam int FW   = fvi_pkg::FIELD_W;
  localparam int NA   = fvi_pkg::NUM_AXES;
  localparam int EW   = (WORD_WIDTH > FW) ? FW : WORD_WIDTH;
  localparam int SQW  = 2 * EW + 4;
  localparam int D2W  = 2 * EW - 3;
  localparam int VMW  = EW + 1;
  localparam int RTW  = SQW / 2;
  localparam int DENW = RTW + SQW;
  localparam int NUMW = VMW + D2W + fvi_pkg::FRAC_W;
  localparam int QB   = EW + 1;
  localparam int SBW  = SQW + D2W + NA * VMW + NA + 1;
  localparam int TSBW = NA + 1;
  localparam logic [QB-1:0] CAP_POS = (QB'(1) << (EW - 1)) - QB'(1);
  localparam logic [QB-1:0] CAP_NEG = QB'(1) << (EW - 1);

  // configuration registers
  logic [FW-1:0] cx_r, cy_r, cz_r, nx_r, ny_r, nz_r;
  logic [FW-2:0] rwid_r, rhgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= '0;
      nx_r   <= '0;
      ny_r   <= FW'(65536);
      nz_r   <= '0;
      rwid_r <= (FW-1)'(65536);
      rhgt_r <= (FW-1)'(65536);
    end else if (cfg_we) begin
      case (fvi_pkg::cfg_idx_t'(cfg_index))
        fvi_pkg::CFG_CENTER_X:    cx_r   <= cfg_wdata;
        fvi_pkg::CFG_CENTER_Y:    cy_r   <= cfg_wdata;
        fvi_pkg::CFG_CENTER_Z:    cz_r   <= cfg_wdata;
        fvi_pkg::CFG_NORMAL_X:    nx_r   <= cfg_wdata;
        fvi_pkg::CFG_NORMAL_Y:    ny_r   <= cfg_wdata;
        fvi_pkg::CFG_NORMAL_Z:    nz_r   <= cfg_wdata;
        fvi_pkg::CFG_RECT_WIDTH:  rwid_r <= cfg_wdata[FW-2:0];
        fvi_pkg::CFG_RECT_HEIGHT: rhgt_r <= cfg_wdata[FW-2:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register is empty or being taken
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // front end
  logic                    fr_vld;
  logic [SQW-1:0]          fr_d2, fr_rad;
  logic [D2W-1:0]          fr_bd2;
  logic [NA-1:0][VMW-1:0]  fr_vm;
  logic [NA-1:0]           fr_vn;
  logic                    fr_flt;

  fvi_front #(.EW(EW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .pos     ({in_pos_z, in_pos_y, in_pos_x}),
    .center  ({cz_r, cy_r, cx_r}),
    .normal  ({nz_r, ny_r, nx_r}),
    .rwid    (rwid_r[EW-2:0]),
    .rhgt    (rhgt_r[EW-2:0]),
    .out_vld (fr_vld),
    .d2      (fr_d2),
    .rad     (fr_rad),
    .big_d2  (fr_bd2),
    .vmag    (fr_vm),
    .vneg    (fr_vn),
    .fault   (fr_flt)
  );

  // square root of the direction length squared
  logic                    sq_vld;
  logic [RTW-1:0]          sq_root;
  logic [SBW-1:0]          sq_sb;
  logic [SQW-1:0]          sq_d2;
  logic [D2W-1:0]          sq_bd2;
  logic [NA-1:0][VMW-1:0]  sq_vm;
  logic [TSBW-1:0]         sq_tail;

  fvi_sqrt #(.SW(SQW), .SBW(SBW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .in_sb    ({fr_d2, fr_bd2, fr_vm, fr_vn, fr_flt}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  assign {sq_d2, sq_bd2, sq_vm, sq_tail} = sq_sb;

  // divisor and dividends
  logic                    sc_vld;
  logic [DENW-1:0]         sc_den;
  logic [NA-1:0][NUMW-1:0] sc_num;
  logic [TSBW-1:0]         sc_tail;

  fvi_scale #(
    .RTW (RTW),
    .SQW (SQW),
    .D2W (D2W),
    .VMW (VMW),
    .SBW (TSBW)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .root    (sq_root),
    .d2      (sq_d2),
    .big_d2  (sq_bd2),
    .vmag    (sq_vm),
    .in_sb   (sq_tail),
    .out_vld (sc_vld),
    .den     (sc_den),
    .num     (sc_num),
    .out_sb  (sc_tail)
  );

  // quotients
  logic                    dv_vld;
  logic [NA-1:0][QB-1:0]   dv_q;
  logic [NA-1:0]           dv_ovf;
  logic [TSBW-1:0]         dv_tail;
  logic [NA-1:0]           dv_neg;
  logic                    dv_flt;

  fvi_div #(
    .DENW (DENW),
    .NUMW (NUMW),
    .QB   (QB),
    .SBW  (TSBW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sc_vld),
    .den     (sc_den),
    .num     (sc_num),
    .in_sb   (sc_tail),
    .out_vld (dv_vld),
    .quo     (dv_q),
    .ovf     (dv_ovf),
    .out_sb  (dv_tail)
  );

  assign {dv_neg, dv_flt} = dv_tail;

  // saturate, apply sign, force zero on fault
  logic [NA-1:0][FW-1:0] vel_nxt;
  logic [NA-1:0][FW-1:0] vel_r;
  logic                  flt_r;

  always_comb begin
    logic [QB-1:0] cap;
    logic [QB-1:0] mg;
    logic [FW:0]   mx;
    for (int a = 0; a < NA; a++) begin
      cap = dv_neg[a] ? CAP_NEG : CAP_POS;
      mg  = (dv_ovf[a] || (dv_q[a] > cap)) ? cap : dv_q[a];
      mx  = (FW+1)'(mg);
      if (dv_neg[a]) begin
        mx = ~mx + (FW+1)'(1);
      end
      vel_nxt[a] = dv_flt ? '0 : mx[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_r <= vel_nxt;
      flt_r <= dv_flt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vel_x     = vel_r[0];
  assign out_vel_y     = vel_r[1];
  assign out_vel_z     = vel_r[2];
  assign out_div_fault = flt_r;

endmodule

`default_nettype wire

// ===== src/fvi_front.sv =====
// fvi_front: three stage front end, offsets, squares, sums and the zero checks
// depends on fvi_pkg
`timescale 1ns / 1ps
`default_nettype none

module fvi_front #(
  parameter int EW = 32
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 en,
  input  logic                                                 in_vld,
  input  logic [fvi_pkg::NUM_AXES-1:0][fvi_pkg::FIELD_W-1:0]   pos,
  input  logic [fvi_pkg::NUM_AXES-1:0][fvi_pkg::FIELD_W-1:0]   center,
  input  logic [fvi_pkg::NUM_AXES-1:0][fvi_pkg::FIELD_W-1:0]   normal,
  input  logic [EW-2:0]                                        rwid,
  input  logic [EW-2:0]                                        rhgt,
  output logic                                                 out_vld,
  output logic [2*EW+3:0]                                      d2,
  output logic [2*EW+3:0]                                      rad,
  output logic [2*EW-4:0]                                      big_d2,
  output logic [fvi_pkg::NUM_AXES-1:0][EW:0]                   vmag,
  output logic [fvi_pkg::NUM_AXES-1:0]                         vneg,
  output logic                                                 fault
);

  localparam int NA  = fvi_pkg::NUM_AXES;
  localparam int SQW = 2 * EW + 4;
  localparam int PW  = 2 * EW + 2;
  localparam int HW2 = 2 * EW - 2;

  // stage 1
  logic                  vld1_r;
  logic [NA-1:0][EW:0]   dm_r, dm_nxt;
  logic [NA-1:0][EW:0]   vm_r, vm_nxt;
  logic [NA-1:0]         vn_r, vn_nxt;
  logic                  flt1_r, flt1_nxt;
  // stage 2
  logic                  vld2_r;
  logic [NA-1:0][PW-1:0] dsq_r, vsq_r;
  logic [HW2-1:0]        hh_r, ww_r;
  logic [NA-1:0][EW:0]   vm2_r;
  logic [NA-1:0]         vn2_r;
  logic                  flt2_r;
  // stage 3
  logic                  vld3_r;
  logic [SQW-1:0]        d2_r, d2_nxt, rad_r, rad_nxt;
  logic [HW2:0]          hsum;
  logic [2*EW-4:0]       bd2_r;
  logic [NA-1:0][EW:0]   vm3_r;
  logic [NA-1:0]         vn3_r;
  logic                  flt3_r;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    logic [EW+1:0] p_x, c_x, n_x, dd, vv, dneg, vneg_x;
    assign p_x    = {{2{pos[a][EW-1]}}, pos[a][EW-1:0]};
    assign c_x    = {{2{center[a][EW-1]}}, center[a][EW-1:0]};
    assign n_x    = {{2{normal[a][EW-1]}}, normal[a][EW-1:0]};
    assign dd     = p_x - c_x;
    assign vv     = p_x + n_x - c_x;
    assign dneg   = ~dd + (EW+2)'(1);
    assign vneg_x = ~vv + (EW+2)'(1);
    assign dm_nxt[a] = dd[EW+1] ? dneg[EW:0] : dd[EW:0];
    assign vm_nxt[a] = vv[EW+1] ? vneg_x[EW:0] : vv[EW:0];
    assign vn_nxt[a] = vv[EW+1];
  end

  // a sum of squares is zero only when every term is zero
  assign flt1_nxt = (dm_nxt == '0) || (vm_nxt == '0);

  always_comb begin
    d2_nxt  = '0;
    rad_nxt = '0;
    for (int a = 0; a < NA; a++) begin
      d2_nxt  = d2_nxt + SQW'(dsq_r[a]);
      rad_nxt = rad_nxt + SQW'(vsq_r[a]);
    end
  end

  assign hsum = (HW2+1)'(hh_r) + (HW2+1)'(ww_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r   <= dm_nxt;
      vm_r   <= vm_nxt;
      vn_r   <= vn_nxt;
      flt1_r <= flt1_nxt;
      for (int a = 0; a < NA; a++) begin
        dsq_r[a] <= PW'(dm_r[a]) * PW'(dm_r[a]);
        vsq_r[a] <= PW'(vm_r[a]) * PW'(vm_r[a]);
      end
      hh_r   <= HW2'(rhgt) * HW2'(rhgt);
      ww_r   <= HW2'(rwid) * HW2'(rwid);
      vm2_r  <= vm_r;
      vn2_r  <= vn_r;
      flt2_r <= flt1_r;
      d2_r   <= d2_nxt;
      rad_r  <= rad_nxt;
      bd2_r  <= hsum[HW2:2];
      vm3_r  <= vm2_r;
      vn3_r  <= vn2_r;
      flt3_r <= flt2_r;
    end
  end

  assign out_vld = vld3_r;
  assign d2      = d2_r;
  assign rad     = rad_r;
  assign big_d2  = bd2_r;
  assign vmag    = vm3_r;
  assign vneg    = vn3_r;
  assign fault   = flt3_r;

endmodule

`default_nettype wire

// ===== src/fvi_sqrt.sv =====
// fvi_sqrt: pipelined digit by digit integer square root, one root bit per stage
// depends on nothing; side data travels alongside each item
`timescale 1ns / 1ps
`default_nettype none

module fvi_sqrt #(
  parameter int SW  = 68,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SW-1:0]     in_rad,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_vld,
  output logic [SW/2-1:0]   out_root,
  output logic [SBW-1:0]    out_sb
);

  localparam int RW = SW / 2;

  logic              vld_r  [RW];
  logic [SW-1:0]     rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SBW-1:0]    sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    localparam int BI = RW - 1 - k;
    logic            vld_in;
    logic [SW-1:0]   rem_in, rem_nxt;
    logic [RW-1:0]   root_in, root_nxt;
    logic [SBW-1:0]  sb_in;
    logic [SW:0]     trial;
    logic            take;

    if (k == 0) begin : g_head
      assign vld_in  = in_vld;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_link
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i); the two terms never overlap
    assign trial = ((SW+1)'(root_in) << (BI + 1)) | ((SW+1)'(1) << (2 * BI));
    assign take  = ((SW+1)'(rem_in) >= trial);

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (take) begin
        rem_nxt      = rem_in - trial[SW-1:0];
        root_nxt[BI] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

`default_nettype wire

// ===== src/fvi_scale.sv =====
// fvi_scale: two stage split multipliers building the divisor and the three dividends
// depends on fvi_pkg
`timescale 1ns / 1ps
`default_nettype none

module fvi_scale #(
  parameter int RTW = 34,
  parameter int SQW = 68,
  parameter int D2W = 61,
  parameter int VMW = 33,
  parameter int SBW = 4
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  logic                                                       en,
  input  logic                                                       in_vld,
  input  logic [RTW-1:0]                                             root,
  input  logic [SQW-1:0]                                             d2,
  input  logic [D2W-1:0]                                             big_d2,
  input  logic [fvi_pkg::NUM_AXES-1:0][VMW-1:0]                      vmag,
  input  logic [SBW-1:0]                                             in_sb,
  output logic                                                       out_vld,
  output logic [RTW+SQW-1:0]                                         den,
  output logic [fvi_pkg::NUM_AXES-1:0][VMW+D2W+fvi_pkg::FRAC_W-1:0]  num,
  output logic [SBW-1:0]                                             out_sb
);

  localparam int NA   = fvi_pkg::NUM_AXES;
  localparam int HW   = SQW / 2;
  localparam int DL   = (D2W + 1) / 2;
  localparam int DH   = D2W - DL;
  localparam int DENW = RTW + SQW;
  localparam int NUMW = VMW + D2W + fvi_pkg::FRAC_W;

  logic                        vld_a_r, vld_b_r;
  logic [RTW+HW-1:0]           dlo_r;
  logic [RTW+SQW-HW-1:0]       dhi_r;
  logic [NA-1:0][VMW+DL-1:0]   nlo_r;
  logic [NA-1:0][VMW+DH-1:0]   nhi_r;
  logic [SBW-1:0]              sb_a_r, sb_b_r;
  logic [DENW-1:0]             den_r, den_nxt;
  logic [NA-1:0][NUMW-1:0]     num_r, num_nxt;

  assign den_nxt = (DENW'(dhi_r) << HW) + DENW'(dlo_r);

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      num_nxt[a] = ((NUMW'(nhi_r[a]) << DL) + NUMW'(nlo_r[a])) << fvi_pkg::FRAC_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlo_r <= (RTW+HW)'(root) * (RTW+HW)'(d2[HW-1:0]);
      dhi_r <= (RTW+SQW-HW)'(root) * (RTW+SQW-HW)'(d2[SQW-1:HW]);
      for (int a = 0; a < NA; a++) begin
        nlo_r[a] <= (VMW+DL)'(vmag[a]) * (VMW+DL)'(big_d2[DL-1:0]);
        nhi_r[a] <= (VMW+DH)'(vmag[a]) * (VMW+DH)'(big_d2[D2W-1:DL]);
      end
      sb_a_r <= in_sb;
      den_r  <= den_nxt;
      num_r  <= num_nxt;
      sb_b_r <= sb_a_r;
    end
  end

  assign out_vld = vld_b_r;
  assign den     = den_r;
  assign num     = num_r;
  assign out_sb  = sb_b_r;

endmodule

`default_nettype wire

// ===== src/fvi_div.sv =====
// fvi_div: pipelined restoring divider, one quotient bit per stage for three lanes
// sharing one divisor; the first stage flags quotients too large to hold; depends on fvi_pkg
`timescale 1ns / 1ps
`default_nettype none

module fvi_div #(
  parameter int DENW = 102,
  parameter int NUMW = 110,
  parameter int QB   = 33,
  parameter int SBW  = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      in_vld,
  input  logic [DENW-1:0]                           den,
  input  logic [fvi_pkg::NUM_AXES-1:0][NUMW-1:0]    num,
  input  logic [SBW-1:0]                            in_sb,
  output logic                                      out_vld,
  output logic [fvi_pkg::NUM_AXES-1:0][QB-1:0]      quo,
  output logic [fvi_pkg::NUM_AXES-1:0]              ovf,
  output logic [SBW-1:0]                            out_sb
);

  localparam int NA = fvi_pkg::NUM_AXES;
  localparam int NS = QB + 1;
  localparam int CW = DENW + QB;

  logic                       vld_r [NS];
  logic [DENW-1:0]            den_r [NS];
  logic [NA-1:0][NUMW-1:0]    rem_r [NS];
  logic [NA-1:0][QB-1:0]      q_r   [NS];
  logic [NA-1:0]              ovf_r [NS];
  logic [SBW-1:0]             sb_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic                     vld_in;
    logic [DENW-1:0]          den_in;
    logic [SBW-1:0]           sb_in;
    logic [NA-1:0][NUMW-1:0]  rem_nxt;
    logic [NA-1:0][QB-1:0]    q_nxt;
    logic [NA-1:0]            ovf_nxt;

    if (k == 0) begin : g_head
      logic [CW-1:0] top_lim;
      assign vld_in  = in_vld;
      assign den_in  = den;
      assign sb_in   = in_sb;
      assign top_lim = CW'(den) << QB;
      // quotient of 2^QB or more saturates anyway
      always_comb begin
        for (int a = 0; a < NA; a++) begin
          rem_nxt[a] = num[a];
          q_nxt[a]   = '0;
          ovf_nxt[a] = (CW'(num[a]) >= top_lim);
        end
      end
    end else begin : g_bit
      localparam int BI = QB - k;
      logic [CW-1:0] trial;
      assign vld_in = vld_r[k-1];
      assign den_in = den_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign trial  = CW'(den_r[k-1]) << BI;
      always_comb begin
        for (int a = 0; a < NA; a++) begin
          rem_nxt[a] = rem_r[k-1][a];
          q_nxt[a]   = q_r[k-1][a];
          ovf_nxt[a] = ovf_r[k-1][a];
          if (CW'(rem_r[k-1][a]) >= trial) begin
            rem_nxt[a]   = rem_r[k-1][a] - trial[NUMW-1:0];
            q_nxt[a][BI] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_nxt;
        sb_r[k]  <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign quo     = q_r[NS-1];
  assign ovf     = ovf_r[NS-1];
  assign out_sb  = sb_r[NS-1];

endmodule

`default_nettype wire
